### sv/i2cpm_pkg.sv
package i2cpm_pkg;

  localparam int unsigned UPPER_PAGES = 4;
  localparam int unsigned PAGE_BYTES  = 128;
  localparam int unsigned STORE_BYTES = PAGE_BYTES * (1 + UPPER_PAGES);

  localparam int unsigned PAGE_SELECT = 127;
  localparam int unsigned CMD_OFFSET  = 78;
  localparam int unsigned ADDR_HI     = 74;
  localparam int unsigned ADDR_LO     = 75;
  localparam int unsigned DATA_HI     = 76;
  localparam int unsigned DATA_LO     = 77;

  localparam logic [7:0] SKIP_BYTE = 8'd80;
  localparam logic [7:0] CMD_LIMIT = 8'd3;
  localparam logic [7:0] CMD_WRITE = 8'd2;

  typedef enum logic [2:0] {
    OP_ADDR_READ  = 3'd0,
    OP_ADDR_WRITE = 3'd1,
    OP_READ_DATA  = 3'd2,
    OP_RX_BYTE    = 3'd3,
    OP_STOP       = 3'd4,
    OP_REPLY      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    BR_NONE  = 2'd0,
    BR_READ  = 2'd1,
    BR_WRITE = 2'd2
  } br_e;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    br_e         bridge_request;
    logic [15:0] bridge_address;
    logic [15:0] bridge_data;
  } res_t;

  typedef logic [15:0] img_idx_t;

  // power-up contents of the memory map
  function automatic logic [7:0] image_byte(input img_idx_t idx);
    logic [7:0] v;
    v = 8'd0;
    case (idx) inside
      16'd0:   v = 8'd17;
      16'd1:   v = 8'd7;
      16'd6:   v = 8'd1;
      16'd22:  v = 8'd16;
      16'd23:  v = 8'd227;
      16'd26:  v = 8'd132;
      16'd27:  v = 8'd157;
      16'd98:  v = 8'd255;
      16'd109: v = 8'd2;
      16'd110: v = 8'd8;
      16'd128: v = 8'd17;
      16'd129: v = 8'd204;
      16'd130: v = 8'd33;
      16'd131: v = 8'd128;
      16'd139: v = 8'd5;
      16'd140: v = 8'd255;
      16'd146: v = 8'd3;
      16'd147: v = 8'd240;
      16'd148: v = 8'd79;
      16'd149: v = 8'd69;
      16'd150: v = 8'd77;
      16'd152: v = 8'd67;
      16'd153: v = 8'd79;
      16'd154: v = 8'd82;
      16'd155: v = 8'd80;
      16'd164: v = 8'd31;
      16'd166: v = 8'd144;
      16'd167: v = 8'd101;
      16'd184: v = 8'd49;
      16'd185: v = 8'd54;
      16'd191: v = 8'd54;
      16'd192: v = 8'd25;
      16'd193: v = 8'd7;
      16'd194: v = 8'd255;
      16'd195: v = 8'd220;
      16'd196: v = 8'd67;
      16'd197: v = 8'd114;
      16'd198: v = 8'd101;
      16'd199: v = 8'd100;
      16'd200: v = 8'd111;
      16'd212: v = 8'd49;
      16'd213: v = 8'd56;
      16'd214: v = 8'd48;
      16'd215: v = 8'd49;
      16'd216: v = 8'd48;
      16'd217: v = 8'd52;
      16'd220: v = 8'd8;
      16'd222: v = 8'd103;
      16'd223: v = 8'd36;
      16'd151, [16'd156:16'd163], [16'd201:16'd211], 16'd218, 16'd219,
      [16'd224:16'd239]: v = 8'd32;
      16'd512: v = 8'd75;
      16'd514: v = 8'd251;
      16'd516: v = 8'd70;
      16'd528: v = 8'd141;
      16'd529: v = 8'd204;
      16'd530: v = 8'd116;
      16'd531: v = 8'd4;
      16'd532: v = 8'd135;
      16'd533: v = 8'd90;
      16'd534: v = 8'd121;
      16'd535: v = 8'd24;
      16'd560: v = 8'd85;
      16'd561: v = 8'd118;
      16'd562: v = 8'd1;
      16'd563: v = 8'd142;
      16'd564: v = 8'd67;
      16'd565: v = 8'd226;
      16'd566: v = 8'd3;
      16'd567: v = 8'd26;
      16'd568: v = 8'd23;
      16'd569: v = 8'd112;
      16'd570: v = 8'd5;
      16'd571: v = 8'd220;
      16'd572: v = 8'd21;
      16'd573: v = 8'd124;
      16'd574: v = 8'd7;
      16'd575: v = 8'd208;
      16'd608: v = 8'd151;
      16'd609: v = 8'd15;
      16'd618: v = 8'd102;
      16'd619: v = 8'd102;
      16'd620: v = 8'd119;
      16'd621: v = 8'd119;
      16'd622: v = 8'd51;
      16'd623: v = 8'd51;
      16'd624: v = 8'd15;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/i2cpm_if.sv
interface i2cpm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic        master_ack;
  logic [7:0]  rx_byte;
  logic [15:0] reply_word;

  modport source (output valid, output operation, output master_ack, output rx_byte,
                  output reply_word, input ready);
  modport sink (input valid, input operation, input master_ack, input rx_byte,
                input reply_word, output ready);
endinterface

interface i2cpm_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [1:0]  bridge_request;
  logic [15:0] bridge_address;
  logic [15:0] bridge_data;

  modport source (output valid, output tx_valid, output tx_byte, output bridge_request,
                  output bridge_address, output bridge_data, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input bridge_request,
                input bridge_address, input bridge_data, output ready);
endinterface

### sv/i2cpm_ram.sv
module i2cpm_ram #(
  parameter int unsigned Depth = i2cpm_pkg::STORE_BYTES,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/i2cpm_ctrl.sv
module i2cpm_ctrl #(
  parameter int unsigned UpperPages = i2cpm_pkg::UPPER_PAGES,
  parameter int unsigned StoreBytes = i2cpm_pkg::PAGE_BYTES * (1 + UpperPages),
  parameter int unsigned AddrW      = $clog2(StoreBytes)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cpm_in_if.sink          in_i,
  i2cpm_out_if.source       out_o,
  output logic              ram_en_o,
  output logic              ram_we_o,
  output logic [AddrW-1:0]  ram_addr_o,
  output logic [7:0]        ram_wdata_o,
  input  logic [7:0]        ram_rdata_i
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);
  localparam logic [AddrW-1:0] PageAddr = AddrW'(i2cpm_pkg::PAGE_SELECT);
  localparam logic [AddrW-1:0] CmdAddr  = AddrW'(i2cpm_pkg::CMD_OFFSET);
  localparam logic [AddrW-1:0] AddrHi   = AddrW'(i2cpm_pkg::ADDR_HI);
  localparam logic [AddrW-1:0] AddrLo   = AddrW'(i2cpm_pkg::ADDR_LO);
  localparam logic [AddrW-1:0] DataHi   = AddrW'(i2cpm_pkg::DATA_HI);
  localparam logic [AddrW-1:0] DataLo   = AddrW'(i2cpm_pkg::DATA_LO);
  localparam logic [15:0]      StoreLim = 16'(StoreBytes);

  typedef enum logic [11:0] {
    S_FILL     = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_EXEC     = 12'b0000_0000_0100,
    S_TXWAIT   = 12'b0000_0000_1000,
    S_PAGEWAIT = 12'b0000_0001_0000,
    S_BRA      = 12'b0000_0010_0000,
    S_BRB      = 12'b0000_0100_0000,
    S_BRC      = 12'b0000_1000_0000,
    S_BRD      = 12'b0001_0000_0000,
    S_BRE      = 12'b0010_0000_0000,
    S_REPLY    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             wsess_q, wsess_d;
  logic             expect_q, expect_d;
  logic [2:0]       op_q, op_d;
  logic             ack_q, ack_d;
  logic [7:0]       byte_q, byte_d;
  logic [15:0]      reply_q, reply_d;
  i2cpm_pkg::res_t  res_q, res_d;
  i2cpm_pkg::res_t  out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic [AddrW-1:0] ptr_inc;
  logic [15:0]      page_addr;
  logic             is_cmd;

  assign ptr_inc   = (ptr_q == LastAddr) ? '0 : ptr_q + 1'b1;
  assign page_addr = {8'd0, byte_q} + {1'b0, ram_rdata_i, 7'd0};
  assign is_cmd    = (ptr_q == CmdAddr) && (byte_q < i2cpm_pkg::CMD_LIMIT);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    wsess_d     = wsess_q;
    expect_d    = expect_q;
    op_d        = op_q;
    ack_d       = ack_q;
    byte_d      = byte_q;
    reply_d     = reply_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = ptr_q;
    ram_wdata_o = byte_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_FILL: begin
        ram_en_o    = 1'b1;
        ram_we_o    = 1'b1;
        ram_addr_o  = fill_q;
        ram_wdata_o = i2cpm_pkg::image_byte(i2cpm_pkg::img_idx_t'(fill_q));
        if (fill_q == LastAddr) begin
          state_d = S_IDLE;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.operation;
          ack_d   = in_i.master_ack;
          byte_d  = in_i.rx_byte;
          reply_d = in_i.reply_word;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_DONE;
        unique case (op_q)
          i2cpm_pkg::OP_ADDR_READ: begin
            ram_en_o = 1'b1;
            wsess_d  = 1'b0;
            state_d  = S_TXWAIT;
          end
          i2cpm_pkg::OP_ADDR_WRITE: begin
            wsess_d  = 1'b1;
            expect_d = 1'b1;
          end
          i2cpm_pkg::OP_READ_DATA: begin
            if (ack_q) begin
              ram_en_o = 1'b1;
              state_d  = S_TXWAIT;
            end
          end
          i2cpm_pkg::OP_RX_BYTE: begin
            if (wsess_q && byte_q != i2cpm_pkg::SKIP_BYTE) begin
              expect_d = 1'b0;
              if (expect_q) begin
                if (byte_q[7]) begin
                  ram_en_o   = 1'b1;
                  ram_addr_o = PageAddr;
                  state_d    = S_PAGEWAIT;
                end else begin
                  ptr_d = AddrW'(byte_q);
                end
              end else begin
                ram_en_o = 1'b1;
                ram_we_o = 1'b1;
                ptr_d    = ptr_inc;
                if (is_cmd) begin
                  // command byte self-clears
                  ram_wdata_o = 8'd0;
                  state_d     = S_BRA;
                end
              end
            end
          end
          i2cpm_pkg::OP_REPLY: begin
            ram_en_o    = 1'b1;
            ram_we_o    = 1'b1;
            ram_addr_o  = DataHi;
            ram_wdata_o = reply_q[15:8];
            state_d     = S_REPLY;
          end
          default: begin
          end
        endcase
      end
      S_TXWAIT: begin
        res_d.tx_valid = 1'b1;
        res_d.tx_byte  = ram_rdata_i;
        ptr_d          = ptr_inc;
        state_d        = S_DONE;
      end
      S_PAGEWAIT: begin
        ptr_d   = (page_addr < StoreLim) ? page_addr[AddrW-1:0] : '0;
        state_d = S_DONE;
      end
      S_BRA: begin
        ram_en_o   = 1'b1;
        ram_addr_o = AddrHi;
        state_d    = S_BRB;
      end
      S_BRB: begin
        ram_en_o                   = 1'b1;
        ram_addr_o                 = AddrLo;
        res_d.bridge_address[15:8] = ram_rdata_i;
        state_d                    = S_BRC;
      end
      S_BRC: begin
        ram_en_o                  = 1'b1;
        ram_addr_o                = DataHi;
        res_d.bridge_address[7:0] = ram_rdata_i;
        state_d                   = S_BRD;
      end
      S_BRD: begin
        ram_en_o                = 1'b1;
        ram_addr_o              = DataLo;
        res_d.bridge_data[15:8] = ram_rdata_i;
        state_d                 = S_BRE;
      end
      S_BRE: begin
        if (byte_q == i2cpm_pkg::CMD_WRITE) begin
          res_d.bridge_request   = i2cpm_pkg::BR_WRITE;
          res_d.bridge_data[7:0] = ram_rdata_i;
        end else begin
          res_d.bridge_request = i2cpm_pkg::BR_READ;
          res_d.bridge_data    = '0;
        end
        state_d = S_DONE;
      end
      S_REPLY: begin
        ram_en_o    = 1'b1;
        ram_we_o    = 1'b1;
        ram_addr_o  = DataLo;
        ram_wdata_o = reply_q[7:0];
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_FILL;
      fill_q    <= '0;
      ptr_q     <= '0;
      wsess_q   <= 1'b0;
      expect_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      ptr_q     <= ptr_d;
      wsess_q   <= wsess_d;
      expect_q  <= expect_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    ack_q   <= ack_d;
    byte_q  <= byte_d;
    reply_q <= reply_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_vld_q;
  assign out_o.tx_valid        = out_q.tx_valid;
  assign out_o.tx_byte         = out_q.tx_byte;
  assign out_o.bridge_request  = out_q.bridge_request;
  assign out_o.bridge_address  = out_q.bridge_address;
  assign out_o.bridge_data     = out_q.bridge_data;

endmodule

### sv/i2c_slave_paged_memory_map_core.sv
// Paged memory map of an I2C slave (emulated module EEPROM): one lower page plus
// UpperPages upper pages in a single-port byte RAM, with offset 127 as page select
// and a bridge mailbox at offsets 74..78. After reset the RAM is loaded with the
// power-up image, one byte per cycle; no word is accepted until that is done. Each
// input word then yields exactly one output word. Cost per word is set by the one
// RAM port: address write, stop, nacked read, ignored bytes and data writes go from
// S_EXEC straight to S_DONE; reads, page-relative addresses and bridge replies pass
// through S_TXWAIT, S_PAGEWAIT or S_REPLY first; a bridge command passes through
// S_BRA..S_BRE, which read offsets 74..77 in turn. The output register is loaded as
// the block returns to idle, where the next word can be taken. A new word is taken
// while a finished one still waits in the output register.
module i2c_slave_paged_memory_map_core #(
  parameter int unsigned UpperPages = i2cpm_pkg::UPPER_PAGES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cpm_in_if.sink     in_i,
  i2cpm_out_if.source  out_o
);

  localparam int unsigned StoreBytes = i2cpm_pkg::PAGE_BYTES * (1 + UpperPages);
  localparam int unsigned AddrW      = $clog2(StoreBytes);

  logic             ram_en;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  i2cpm_ctrl #(
    .UpperPages (UpperPages),
    .StoreBytes (StoreBytes),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  i2cpm_ram #(
    .Depth (StoreBytes),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
